// File: design/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared kind codes, payload and stage types, and kind helper functions
// for the numeric type converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // Kind codes; codes above KIND_U8 are unsupported
    localparam logic [3:0] KIND_F64 = 4'd0;
    localparam logic [3:0] KIND_F32 = 4'd1;
    localparam logic [3:0] KIND_I64 = 4'd2;
    localparam logic [3:0] KIND_I32 = 4'd3;
    localparam logic [3:0] KIND_I16 = 4'd4;
    localparam logic [3:0] KIND_I8  = 4'd5;
    localparam logic [3:0] KIND_U64 = 4'd6;
    localparam logic [3:0] KIND_U32 = 4'd7;
    localparam logic [3:0] KIND_U16 = 4'd8;
    localparam logic [3:0] KIND_U8  = 4'd9;

    localparam int EXP_W = 13;

    typedef struct packed {
        logic [3:0]  source_kind;
        logic [3:0]  target_kind;
        logic [63:0] source_bits;
    } ntc_in_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        range_flag;
        logic        kind_error;
    } ntc_out_t;

    // Number in flight: value = mag * 2^(exp - 63), or a result already known
    typedef struct packed {
        logic                    direct;
        logic [63:0]             direct_bits;
        logic                    direct_flag;
        logic                    kind_error;
        logic [3:0]              target_kind;
        logic                    sign;
        logic signed [EXP_W-1:0] exp;
        logic [63:0]             mag;
        logic [2:0]              shift_amt;
    } ntc_num_t;

    // After alignment: packed base plus rounding bits, or truncated integer
    typedef struct packed {
        logic        direct;
        logic [63:0] direct_bits;
        logic        direct_flag;
        logic        kind_error;
        logic [3:0]  target_kind;
        logic        sign;
        logic [63:0] value;
        logic        guard;
        logic        sticky;
        logic        ovf;
    } ntc_rnd_t;

    function automatic logic kind_valid(logic [3:0] k);
        return k <= KIND_U8;
    endfunction

    function automatic logic kind_is_float(logic [3:0] k);
        return (k == KIND_F64) || (k == KIND_F32);
    endfunction

    function automatic logic kind_signed(logic [3:0] k);
        return (k >= KIND_I64) && (k <= KIND_I8);
    endfunction

    function automatic logic [6:0] kind_width(logic [3:0] k);
        logic [6:0] w;
        case (k) inside
            KIND_F64, KIND_I64, KIND_U64: w = 7'd64;
            KIND_F32, KIND_I32, KIND_U32: w = 7'd32;
            KIND_I16, KIND_U16:           w = 7'd16;
            default:                      w = 7'd8;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] kind_mask(logic [3:0] k);
        logic [63:0] m;
        case (kind_width(k))
            7'd64:   m = '1;
            7'd32:   m = 64'h0000_0000_FFFF_FFFF;
            7'd16:   m = 64'h0000_0000_0000_FFFF;
            default: m = 64'h0000_0000_0000_00FF;
        endcase
        return m;
    endfunction

    // Saturation bounds of an integer kind
    function automatic logic [63:0] sat_max(logic [3:0] k);
        return kind_signed(k) ? (kind_mask(k) >> 1) : kind_mask(k);
    endfunction

    function automatic logic [63:0] sat_min(logic [3:0] k);
        return kind_signed(k) ? (~(kind_mask(k) >> 1) & kind_mask(k)) : 64'd0;
    endfunction

endpackage

// File: design/ntc_chan_if.sv
// ----------------------------------------------------------------------------
// ntc_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ntc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/ntc_unpack.sv
// ----------------------------------------------------------------------------
// ntc_unpack
// Stage 1: decode kinds, settle special cases, unpack the value into
// sign / exponent / magnitude and find the leading nonzero byte.
// ----------------------------------------------------------------------------
module ntc_unpack
    import ntc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  ntc_in_t  in_data,
    output logic     valid_reg,
    output ntc_num_t num_reg
);

    ntc_num_t num_next;

    always_comb
    begin
        logic [3:0]  sk;
        logic [3:0]  tk;
        logic [63:0] s;
        logic [63:0] v;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        fsign;
        sk = in_data.source_kind;
        tk = in_data.target_kind;
        s  = in_data.source_bits;
        v  = '0;
        is_nan  = 1'b0;
        is_inf  = 1'b0;
        is_zero = 1'b0;
        fsign   = 1'b0;

        num_next             = '0;
        num_next.target_kind = tk;

        if (!kind_valid(sk) || !kind_valid(tk))
        begin
            num_next.direct     = 1'b1;
            num_next.kind_error = 1'b1;
        end
        else if (kind_is_float(sk))
        begin
            // Float source: classify and unpack
            if (sk == KIND_F64)
            begin
                fsign   = s[63];
                is_nan  = (s[62:52] == '1) && (s[51:0] != '0);
                is_inf  = (s[62:52] == '1) && (s[51:0] == '0);
                is_zero = (s[62:0] == '0);
                if (s[62:52] == '0)
                begin
                    num_next.exp = -13'sd1022;
                    num_next.mag = {1'b0, s[51:0], 11'b0};
                end
                else
                begin
                    num_next.exp = $signed({2'b00, s[62:52]}) - 13'sd1023;
                    num_next.mag = {1'b1, s[51:0], 11'b0};
                end
            end
            else
            begin
                fsign   = s[31];
                is_nan  = (s[30:23] == '1) && (s[22:0] != '0);
                is_inf  = (s[30:23] == '1) && (s[22:0] == '0);
                is_zero = (s[30:0] == '0);
                if (s[30:23] == '0)
                begin
                    num_next.exp = -13'sd126;
                    num_next.mag = {1'b0, s[22:0], 40'b0};
                end
                else
                begin
                    num_next.exp = $signed({5'b0, s[30:23]}) - 13'sd127;
                    num_next.mag = {1'b1, s[22:0], 40'b0};
                end
            end
            num_next.sign = fsign;

            if (tk == sk)
            begin
                num_next.direct      = 1'b1;
                num_next.direct_bits = s & kind_mask(sk);
            end
            else if (is_nan)
            begin
                num_next.direct = 1'b1;
                if (tk == KIND_F64)
                    num_next.direct_bits = {fsign, 11'h7FF, 1'b1, s[21:0], 29'b0};
                else if (tk == KIND_F32)
                    num_next.direct_bits = {32'b0, fsign, 8'hFF, 1'b1, s[50:29]};
                else
                    num_next.direct_flag = 1'b1;
            end
            else if (is_inf)
            begin
                num_next.direct = 1'b1;
                if (tk == KIND_F64)
                    num_next.direct_bits = {fsign, 11'h7FF, 52'b0};
                else if (tk == KIND_F32)
                    num_next.direct_bits = {32'b0, fsign, 8'hFF, 23'b0};
                else
                begin
                    num_next.direct_flag = 1'b1;
                    num_next.direct_bits = fsign ? sat_min(tk) : sat_max(tk);
                end
            end
            else if (is_zero)
            begin
                num_next.direct = 1'b1;
                if (tk == KIND_F64)
                    num_next.direct_bits = {fsign, 63'b0};
                else if (tk == KIND_F32)
                    num_next.direct_bits = {32'b0, fsign, 31'b0};
            end
        end
        else
        begin
            // Integer source: extend per source kind
            case (kind_width(sk))
                7'd64:   v = s;
                7'd32:   v = kind_signed(sk) ? {{32{s[31]}}, s[31:0]} : {32'b0, s[31:0]};
                7'd16:   v = kind_signed(sk) ? {{48{s[15]}}, s[15:0]} : {48'b0, s[15:0]};
                default: v = kind_signed(sk) ? {{56{s[7]}}, s[7:0]} : {56'b0, s[7:0]};
            endcase
            num_next.sign = kind_signed(sk) && v[63];
            num_next.mag  = num_next.sign ? (~v + 64'd1) : v;
            num_next.exp  = 13'sd63;
            if (!kind_is_float(tk))
            begin
                num_next.direct      = 1'b1;
                num_next.direct_bits = v & kind_mask(tk);
            end
            else if (v == '0)
            begin
                num_next.direct = 1'b1;
            end
        end

        // Leading nonzero byte
        num_next.shift_amt = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (num_next.mag[i*8 +: 8] != '0)
                num_next.shift_amt = 3'(7 - i);
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            num_reg <= num_next;
    end

endmodule

// File: design/ntc_normalize.sv
// ----------------------------------------------------------------------------
// ntc_normalize
// Stages 2 and 3: normalize the magnitude so its top bit is set, first by
// whole bytes, then by bits within the leading byte.
// ----------------------------------------------------------------------------
module ntc_normalize
    import ntc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  ntc_num_t in_num,
    output logic     valid_reg,
    output ntc_num_t num_reg
);

    logic     mid_valid_reg;
    ntc_num_t mid_reg;
    ntc_num_t mid_next;
    ntc_num_t num_next;

    // Byte shift, then leading bit count in the top byte
    always_comb
    begin
        mid_next     = in_num;
        mid_next.mag = in_num.mag << {in_num.shift_amt, 3'b000};
        mid_next.exp = in_num.exp - $signed(EXP_W'({in_num.shift_amt, 3'b000}));
        mid_next.shift_amt = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (mid_next.mag[56 + i])
                mid_next.shift_amt = 3'(7 - i);
        end
    end

    // Bit shift
    always_comb
    begin
        num_next     = mid_reg;
        num_next.mag = mid_reg.mag << mid_reg.shift_amt;
        num_next.exp = mid_reg.exp - $signed(EXP_W'(mid_reg.shift_amt));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= in_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_reg <= mid_next;
            num_reg <= num_next;
        end
    end

endmodule

// File: design/ntc_round.sv
// ----------------------------------------------------------------------------
// ntc_round
// Stages 4 and 5: align the normalized value to the target (mantissa and
// rounding bits, or truncated integer), then round, saturate and pack.
// ----------------------------------------------------------------------------
module ntc_round
    import ntc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  ntc_num_t in_num,
    output logic     valid_reg,
    output ntc_out_t out_reg
);

    logic     rnd_valid_reg;
    ntc_rnd_t rnd_reg;
    ntc_rnd_t rnd_next;
    ntc_out_t out_next;

    // Alignment
    always_comb
    begin
        logic signed [EXP_W-1:0] e;
        logic signed [EXP_W-1:0] a;
        logic [5:0]              amt;
        logic [127:0]            wide;
        e    = '0;
        a    = '0;
        amt  = '0;
        wide = '0;

        rnd_next             = '0;
        rnd_next.direct      = in_num.direct;
        rnd_next.direct_bits = in_num.direct_bits;
        rnd_next.direct_flag = in_num.direct_flag;
        rnd_next.kind_error  = in_num.kind_error;
        rnd_next.target_kind = in_num.target_kind;
        rnd_next.sign        = in_num.sign;

        if (in_num.target_kind == KIND_F64)
        begin
            e = in_num.exp + 13'sd1023;
            rnd_next.value  = ({51'b0, e} - 64'd1) << 52;
            rnd_next.value  = rnd_next.value + {11'b0, in_num.mag[63:11]};
            rnd_next.guard  = in_num.mag[10];
            rnd_next.sticky = |in_num.mag[9:0];
        end
        else if (in_num.target_kind == KIND_F32)
        begin
            e = in_num.exp + 13'sd127;
            rnd_next.ovf = (e >= 13'sd255);
            if (e >= 13'sd1)
            begin
                rnd_next.value  = ({56'b0, e[7:0]} - 64'd1) << 23;
                rnd_next.value  = rnd_next.value + {40'b0, in_num.mag[63:40]};
                rnd_next.guard  = in_num.mag[39];
                rnd_next.sticky = |in_num.mag[38:0];
            end
            else
            begin
                // Subnormal result: shift right, collect shifted-out bits
                a   = 13'sd1 - e;
                amt = (a > 13'sd63) ? 6'd63 : a[5:0];
                wide = {in_num.mag, 64'b0} >> amt;
                rnd_next.value  = {40'b0, wide[127:104]};
                rnd_next.guard  = wide[103];
                rnd_next.sticky = (|wide[102:64]) || (|wide[63:0]);
            end
        end
        else
        begin
            // Integer target: truncate toward zero
            rnd_next.ovf = (in_num.exp > 13'sd63);
            a = 13'sd63 - in_num.exp;
            if (in_num.exp < 13'sd0)
                rnd_next.value = '0;
            else
                rnd_next.value = in_num.mag >> a[5:0];
        end
    end

    // Rounding, saturation and packing
    always_comb
    begin
        logic        ru;
        logic [63:0] r64;
        logic [30:0] r31;
        logic [6:0]  w;
        logic [63:0] lim_s;
        logic [64:0] lim_u;
        logic [3:0]  tk;
        tk    = rnd_reg.target_kind;
        ru    = rnd_reg.guard && (rnd_reg.sticky || rnd_reg.value[0]);
        r64   = rnd_reg.value + {63'b0, ru};
        r31   = rnd_reg.value[30:0] + {30'b0, ru};
        w     = kind_width(tk);
        lim_s = 64'd1 << (w - 7'd1);
        lim_u = 65'd1 << w;

        out_next            = '0;
        out_next.kind_error = rnd_reg.kind_error;

        if (rnd_reg.direct)
        begin
            out_next.result_bits = rnd_reg.direct_bits;
            out_next.range_flag  = rnd_reg.direct_flag;
        end
        else if (tk == KIND_F64)
        begin
            out_next.result_bits = {rnd_reg.sign, r64[62:0]};
        end
        else if (tk == KIND_F32)
        begin
            if (rnd_reg.ovf)
                out_next.result_bits = {32'b0, rnd_reg.sign, 8'hFF, 23'b0};
            else
                out_next.result_bits = {32'b0, rnd_reg.sign, r31};
        end
        else if (kind_signed(tk))
        begin
            if (!rnd_reg.sign && (rnd_reg.ovf || rnd_reg.value >= lim_s))
            begin
                out_next.result_bits = sat_max(tk);
                out_next.range_flag  = 1'b1;
            end
            else if (rnd_reg.sign && (rnd_reg.ovf || rnd_reg.value > lim_s))
            begin
                out_next.result_bits = sat_min(tk);
                out_next.range_flag  = 1'b1;
            end
            else if (rnd_reg.sign)
                out_next.result_bits = (~rnd_reg.value + 64'd1) & kind_mask(tk);
            else
                out_next.result_bits = rnd_reg.value & kind_mask(tk);
        end
        else
        begin
            if (rnd_reg.sign)
            begin
                out_next.range_flag = rnd_reg.ovf || (rnd_reg.value != '0);
            end
            else if (rnd_reg.ovf || ({1'b0, rnd_reg.value} >= lim_u))
            begin
                out_next.result_bits = sat_max(tk);
                out_next.range_flag  = 1'b1;
            end
            else
                out_next.result_bits = rnd_reg.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (adv)
        begin
            rnd_valid_reg <= in_valid;
            valid_reg     <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnd_reg <= rnd_next;
            out_reg <= out_next;
        end
    end

endmodule

// File: design/numeric_type_converter.sv
// ----------------------------------------------------------------------------
// numeric_type_converter
// Five-stage pipelined conversion between float and integer kinds.
// Throughput: one transfer per cycle; the whole pipe holds while the
// output is stalled, the last stage acting as the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module numeric_type_converter
    import ntc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ntc_chan_if.sink   req,
    ntc_chan_if.source rsp
);

    logic     adv;
    logic     s1_valid;
    ntc_num_t s1_num;
    logic     s3_valid;
    ntc_num_t s3_num;
    logic     s5_valid;
    ntc_out_t s5_out;

    // Pipe advances unless a finished result is blocked
    assign adv       = !s5_valid || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = s5_valid;
    assign rsp.data  = s5_out;

    ntc_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req.valid),
        .in_data   (req.data),
        .valid_reg (s1_valid),
        .num_reg   (s1_num)
    );

    ntc_normalize u_normalize (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid),
        .in_num    (s1_num),
        .valid_reg (s3_valid),
        .num_reg   (s3_num)
    );

    ntc_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid),
        .in_num    (s3_num),
        .valid_reg (s5_valid),
        .out_reg   (s5_out)
    );

endmodule

// File: sim/numeric_type_converter_tb.sv
// ----------------------------------------------------------------------------
// numeric_type_converter_tb
// Self-checking bench for the numeric type converter. A directed set of edge
// values runs first, then random kind pairs and operands. Every input transfer
// is predicted with integer-only IEEE packing and truncation logic, and results
// are checked in order. The sender works in random bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module numeric_type_converter_tb;
    import ntc_pkg::*;

    localparam int NUM_RANDOM = 1700;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    // Expected conversion results, kept in transfer order
    class conv_scoreboard;
        ntc_out_t expected_q[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Float or integer source as sign * mag * 2^e
        function void unpack_source(ntc_in_t x, output bit is_nan, output bit is_inf,
                                    output bit sgn, output logic [63:0] mag, output int e);
            logic [63:0] v;
            is_nan = 0;
            is_inf = 0;
            e = 0;
            if (x.source_kind == KIND_F64) begin
                sgn = x.source_bits[63];
                mag = {12'd0, x.source_bits[51:0]};
                if (x.source_bits[62:52] == 11'h7FF) begin
                    is_nan = (mag != 0);
                    is_inf = (mag == 0);
                end else if (x.source_bits[62:52] == 0) begin
                    e = -1074;
                end else begin
                    mag[52] = 1'b1;
                    e = int'(x.source_bits[62:52]) - 1075;
                end
            end else if (x.source_kind == KIND_F32) begin
                sgn = x.source_bits[31];
                mag = {41'd0, x.source_bits[22:0]};
                if (x.source_bits[30:23] == 8'hFF) begin
                    is_nan = (mag != 0);
                    is_inf = (mag == 0);
                end else if (x.source_bits[30:23] == 0) begin
                    e = -149;
                end else begin
                    mag[23] = 1'b1;
                    e = int'(x.source_bits[30:23]) - 150;
                end
            end else begin
                v = x.source_bits & kind_mask(x.source_kind);
                if (kind_signed(x.source_kind) && kind_width(x.source_kind) < 64 &&
                    v[kind_width(x.source_kind) - 1])
                    v = v | ~kind_mask(x.source_kind);
                sgn = kind_signed(x.source_kind) && v[63];
                mag = sgn ? -v : v;
            end
        endfunction

        // Round to nearest even into binary64 or binary32
        function logic [63:0] pack_float(bit sgn, logic [63:0] mag, int e, bit dbl);
            int          mw;
            int          ew;
            int          bias;
            int          p;
            int          q;
            int          sh;
            int          be;
            logic [63:0] kept;
            bit          g;
            bit          st;
            mw = dbl ? 52 : 23;
            ew = dbl ? 11 : 8;
            bias = dbl ? 1023 : 127;
            if (mag == 0)
                return dbl ? {sgn, 63'd0} : {32'd0, sgn, 31'd0};
            p = 63;
            while (!mag[p])
                p--;
            q = p - mw + e;
            if (q < 1 - bias - mw)
                q = 1 - bias - mw;
            sh = q - e;
            g = 0;
            st = 0;
            if (sh <= 0) begin
                kept = mag << (-sh);
            end else if (sh > 64) begin
                kept = 0;
                st = 1;
            end else begin
                kept = (sh == 64) ? 64'd0 : (mag >> sh);
                g = mag[sh - 1];
                st = (sh > 1) ? ((mag & ((64'd1 << (sh - 1)) - 1)) != 0) : 1'b0;
            end
            if (g && (st || kept[0]))
                kept++;
            if (kept == (64'd1 << (mw + 1))) begin
                kept = kept >> 1;
                q++;
            end
            be = kept[mw] ? (q + mw + bias) : 0;
            if (be >= (1 << ew) - 1) begin
                be = (1 << ew) - 1;
                kept = 0;
            end
            return dbl ? {sgn, be[10:0], kept[51:0]} : {32'd0, sgn, be[7:0], kept[22:0]};
        endfunction

        // Truncate toward zero into an integer kind, saturating out of range
        function void float_to_int(bit is_nan, bit is_inf, bit sgn, logic [63:0] mag,
                                   int e, logic [3:0] tk, output logic [63:0] res,
                                   output logic flag);
            logic [63:0] ip;
            logic [63:0] m;
            logic [63:0] hi;
            bit          big;
            int          w;
            w = kind_width(tk);
            m = kind_mask(tk);
            flag = 0;
            big = is_inf;
            ip = 0;
            if (!is_inf && !is_nan) begin
                if (e >= 64)
                    big = (mag != 0);
                else if (e > 0)
                    begin
                        big = ((mag >> (64 - e)) != 0);
                        ip = mag << e;
                    end
                else if (e > -64)
                    ip = mag >> (-e);
            end
            if (is_nan) begin
                res = 0;
                flag = 1;
            end else if (kind_signed(tk)) begin
                hi = 64'd1 << (w - 1);
                if (!sgn && (big || ip >= hi)) begin
                    res = m >> 1;
                    flag = 1;
                end else if (sgn && (big || ip >= hi + 1)) begin
                    res = ~(m >> 1) & m;
                    flag = 1;
                end else begin
                    res = (sgn ? -ip : ip) & m;
                end
            end else begin
                if (!sgn && (big || (w < 64 && ip >= (64'd1 << w)))) begin
                    res = m;
                    flag = 1;
                end else if (sgn && (big || ip >= 1)) begin
                    res = 0;
                    flag = 1;
                end else begin
                    res = ip & m;
                end
            end
        endfunction

        function ntc_out_t convert(ntc_in_t x);
            ntc_out_t    r;
            bit          is_nan;
            bit          is_inf;
            bit          sgn;
            logic [63:0] mag;
            int          e;
            r = '0;
            if (!kind_valid(x.source_kind) || !kind_valid(x.target_kind)) begin
                r.kind_error = 1;
                return r;
            end
            unpack_source(x, is_nan, is_inf, sgn, mag, e);
            if (x.target_kind == x.source_kind && kind_is_float(x.source_kind)) begin
                r.result_bits = x.source_bits & kind_mask(x.source_kind);
            end else if (kind_is_float(x.target_kind)) begin
                if (is_nan && x.target_kind == KIND_F64)
                    r.result_bits = {sgn, 12'hFFF, x.source_bits[21:0], 29'd0};
                else if (is_nan)
                    r.result_bits = {32'd0, sgn, 9'h1FF, x.source_bits[50:29]};
                else if (is_inf && x.target_kind == KIND_F64)
                    r.result_bits = {sgn, 11'h7FF, 52'd0};
                else if (is_inf)
                    r.result_bits = {32'd0, sgn, 8'hFF, 23'd0};
                else
                    r.result_bits = pack_float(sgn, mag, e, x.target_kind == KIND_F64);
            end else if (kind_is_float(x.source_kind)) begin
                float_to_int(is_nan, is_inf, sgn, mag, e, x.target_kind,
                             r.result_bits, r.range_flag);
            end else begin
                r.result_bits = (sgn ? -mag : mag) & kind_mask(x.target_kind);
            end
            return r;
        endfunction

        function void note_input(ntc_in_t x);
            expected_q.push_back(convert(x));
        endfunction

        function void check_result(ntc_out_t got);
            ntc_out_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_bits !== want.result_bits || got.range_flag !== want.range_flag ||
                got.kind_error !== want.kind_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected bits=%h flag=%b err=%b, got bits=%h flag=%b err=%b",
                             want.result_bits, want.range_flag, want.kind_error,
                             got.result_bits, got.range_flag, got.kind_error);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ntc_chan_if #(.payload_t(ntc_in_t))  req_if ();
    ntc_chan_if #(.payload_t(ntc_out_t)) rsp_if ();

    numeric_type_converter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    conv_scoreboard sb = new();
    int idle_cycles;
    int stall_mode;
    int stall_phase;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_input(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.data);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** numeric_type_converter: FAILED **");
                $finish;
            end
        end
    end

    // Receiver stall pattern: free running, random, or periodic stalls
    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase % 80 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: rsp_if.ready = 1'b1;
            1: rsp_if.ready = ($urandom_range(0, 1) == 1);
            default: rsp_if.ready = (stall_phase % 11) > 3;
        endcase
    end

    // Present one item and hold it until the transfer
    task automatic send_item(ntc_in_t x);
        req_if.data = x;
        req_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        req_if.valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [3:0] pick_kind();
        return ($urandom_range(0, 99) < 4) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    endfunction

    // Random operand shaped by source kind
    function automatic ntc_in_t random_item();
        ntc_in_t     x;
        logic [63:0] r;
        int          k;
        int          ex;
        x.source_kind = pick_kind();
        x.target_kind = pick_kind();
        r = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k == 0) begin
            x.source_bits = r;
        end else if (x.source_kind == KIND_F64 || x.source_kind == KIND_F32) begin
            if (k < 3)
                ex = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : -1 - $urandom_range(0, 1);
            else
                ex = $urandom_range(0, 69) - 3 + ((x.source_kind == KIND_F64) ? 1023 : 127);
            if ($urandom_range(0, 3) == 0)
                r = r & ~((64'd1 << $urandom_range(0, 52)) - 1);
            if (x.source_kind == KIND_F64) begin
                if (ex < 0) ex = 2047 + ex + 1;
                x.source_bits = {r[63], 11'(ex), r[51:0]};
            end else begin
                if (ex < 0) ex = 255 + ex + 1;
                x.source_bits = {r[63:32], r[63], 8'(ex), r[22:0]};
            end
        end else begin
            r = r >> $urandom_range(0, 63);
            if (k < 4)
                r = (r << 11) | 64'h400;
            if ($urandom_range(0, 1) == 1)
                r = -r;
            x.source_bits = r;
        end
        return x;
    endfunction

    function automatic ntc_in_t make_item(logic [3:0] sk, logic [3:0] tk, logic [63:0] b);
        ntc_in_t x;
        x.source_kind = sk;
        x.target_kind = tk;
        x.source_bits = b;
        return x;
    endfunction

    ntc_in_t directed_q[$];

    initial
    begin
        int sent;
        int burst;
        rst_n = 0;
        req_if.valid = 0;
        req_if.data = '0;
        rsp_if.ready = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_phase = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Edge values: NaN, infinities, saturation bounds, rounding, bad codes
        directed_q.push_back(make_item(KIND_F64, KIND_I32, 64'h7FF8_0000_0000_0001));
        directed_q.push_back(make_item(KIND_F64, KIND_U64, 64'h7FF0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_I8,  64'hFFF0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_U8,  64'hBFE0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_U32, 64'hBFF0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_I64, 64'h43E0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_I64, 64'hC3E0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_U64, 64'h43F0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_U32, 64'h41F0_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F64, KIND_I32, 64'h3FF8_0000_0000_0000));
        directed_q.push_back(make_item(KIND_F32, KIND_I8,  64'hDEAD_BEEF_C301_0000));
        directed_q.push_back(make_item(KIND_F32, KIND_I8,  64'h0000_0000_C300_8000));
        directed_q.push_back(make_item(KIND_F32, KIND_F64, 64'h1234_5678_7FC0_0123));
        directed_q.push_back(make_item(KIND_F64, KIND_F32, 64'hFFF4_0000_0000_00FF));
        directed_q.push_back(make_item(KIND_F64, KIND_F32, 64'h0000_0000_0000_0001));
        directed_q.push_back(make_item(KIND_F64, KIND_F32, 64'h7FEF_FFFF_FFFF_FFFF));
        directed_q.push_back(make_item(KIND_F32, KIND_F32, 64'hFFFF_FFFF_7F80_0001));
        directed_q.push_back(make_item(KIND_F32, KIND_F64, 64'h0000_0000_0000_0001));
        directed_q.push_back(make_item(KIND_I64, KIND_F64, 64'h8000_0000_0000_0000));
        directed_q.push_back(make_item(KIND_U64, KIND_F32, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_q.push_back(make_item(KIND_I64, KIND_F64, 64'h0020_0000_0000_0001));
        directed_q.push_back(make_item(KIND_I8,  KIND_U64, 64'hFFFF_FFFF_FFFF_FF80));
        directed_q.push_back(make_item(KIND_U64, KIND_I16, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_q.push_back(make_item(4'd12, KIND_F64, 64'h0000_0000_0000_0001));
        directed_q.push_back(make_item(KIND_U8, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));

        foreach (directed_q[i]) begin
            send_item(directed_q[i]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 3));
        end

        // Random traffic in bursts with gaps
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                send_item(random_item());
                sent++;
            end
            if ($urandom_range(0, 9) < 6)
                idle_gap($urandom_range(1, 6));
        end
        req_if.valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** numeric_type_converter: PASSED **");
        else
            $display("** numeric_type_converter: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/ntc_pkg.sv
design/ntc_chan_if.sv
design/ntc_unpack.sv
design/ntc_normalize.sv
design/ntc_round.sv
design/numeric_type_converter.sv
sim/numeric_type_converter_tb.sv
